// ----- rtl/wsfe_pkg.sv -----
// Shared constants and types for the WebSocket frame encoder.
package wsfe_pkg;

  localparam int unsigned HdrMax     = 14;   // longest header: 2 + 8 + 4 key bytes
  localparam int unsigned CntW       = 4;    // holds 0..HdrMax
  localparam int unsigned PaddrW     = 3;

  localparam logic [7:0]  FinBit     = 8'h80;
  localparam logic [7:0]  MaskBit    = 8'h80;
  localparam logic [6:0]  Len16Mark  = 7'd126;
  localparam logic [6:0]  Len64Mark  = 7'd127;
  localparam logic [63:0] ShortLim   = 64'd126;
  localparam logic [31:0] KeyReset   = 32'h1234_5678;

  localparam logic [CntW-1:0] NShort = 4'd2;
  localparam logic [CntW-1:0] NMid   = 4'd4;
  localparam logic [CntW-1:0] NLong  = 4'd10;
  localparam logic [CntW-1:0] NKey   = 4'd4;

  typedef enum logic {
    REG_USE_MASK = 1'b0,
    REG_KEY      = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_PAYLOAD = 1'b1
  } mode_e;

  typedef logic [HdrMax-1:0][7:0] hdr_buf_t;

endpackage

// ----- rtl/websocket_frame_encoder.sv -----
// WebSocket frame encoder: header builder, payload masking and output byte serialiser.
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   mode, opcode, payload_length, data_byte
//   out      source     out_valid_o / out_stall_i out_byte, is_header, run_last
//   cfg      APB slave  psel/penable/pwrite       use_mask @0x0, mask key @0x4
//
// A start word builds its whole header (2, 4 or 10 bytes, plus 4 key bytes when masking)
// combinationally and loads it into a shift buffer; the buffer then sends one byte per
// cycle while the output is not stalled. A payload word loads a single byte.
// The next input word is taken in the same cycle as the final byte of the current one
// leaves, so unstalled payload streams at one byte per cycle. The shift buffer sets the rate.
// Reset clears the buffer's valid state, the mask phase and the config registers.
// Output stall freezes the buffer; input stall is then raised until the last byte goes.
module websocket_frame_encoder
  import wsfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [3:0]          opcode_i,
  input  logic [63:0]         payload_length_i,
  input  logic [7:0]          data_byte_i,
  // output bytes
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                is_header_o,
  output logic                run_last_o,
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // config registers
  logic        use_mask_q;
  logic [31:0] key_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_mask_q <= 1'b0;
      key_q      <= KeyReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_USE_MASK: use_mask_q <= pwdata[0];
        REG_KEY:      key_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_USE_MASK: prdata = {31'b0, use_mask_q};
      REG_KEY:      prdata = key_q;
      default:      prdata = '0;
    endcase
  end

  // output shift buffer state
  logic                out_valid_q;
  logic [CntW-1:0]     rem_q;       // bytes still to send, incl. the one on the port
  logic                is_hdr_q;
  hdr_buf_t            buf_q;
  logic [1:0]          phase_q;

  logic take, last, accept;

  assign last       = (rem_q == CntW'(1));
  assign take       = out_valid_q & ~out_stall_i;
  assign in_stall_o = out_valid_q & ~(take & last);
  assign accept     = in_valid_i & ~in_stall_o;

  // header build
  hdr_buf_t        hdr;
  logic [CntW-1:0] hdr_n;
  logic [7:0]      mbit;
  logic [7:0]      key_sel;
  logic [7:0]      pay_byte;
  logic [CntW-1:0] key_at;

  assign mbit = use_mask_q ? MaskBit : 8'h00;

  always_comb begin
    hdr    = '0;
    hdr[0] = FinBit | {4'b0, opcode_i};
    if (payload_length_i < ShortLim) begin
      hdr[1] = mbit | {1'b0, payload_length_i[6:0]};
      key_at = NShort;
    end else if (payload_length_i[63:16] == '0) begin
      hdr[1] = mbit | {1'b0, Len16Mark};
      hdr[2] = payload_length_i[15:8];
      hdr[3] = payload_length_i[7:0];
      key_at = NMid;
    end else begin
      hdr[1] = mbit | {1'b0, Len64Mark};
      for (int i = 0; i < 8; i++) begin
        hdr[2+i] = payload_length_i[63-8*i -: 8];
      end
      key_at = NLong;
    end
    // key bytes go into the four slots after the length; only one class is live
    if (use_mask_q) begin
      for (int k = 0; k < 4; k++) begin
        if (key_at == NShort) hdr[int'(NShort)+k] = key_q[31-8*k -: 8];
        if (key_at == NMid)   hdr[int'(NMid)+k]   = key_q[31-8*k -: 8];
        if (key_at == NLong)  hdr[int'(NLong)+k]  = key_q[31-8*k -: 8];
      end
      hdr_n = key_at + NKey;
    end else begin
      hdr_n = key_at;
    end
  end

  // payload masking: key byte 0 sits in bits 31..24
  always_comb begin
    case (phase_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end
  assign pay_byte = use_mask_q ? (data_byte_i ^ key_sel) : data_byte_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      phase_q     <= '0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      if (mode_e'(mode_i) == MODE_PAYLOAD) begin
        rem_q   <= CntW'(1);
        phase_q <= phase_q + 2'd1;
      end else begin
        rem_q   <= hdr_n;
        phase_q <= '0;
      end
    end else if (take) begin
      out_valid_q <= ~last;
      rem_q       <= rem_q - CntW'(1);
    end
  end

  // shift buffer for header and payload bytes, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (mode_e'(mode_i) == MODE_PAYLOAD) begin
        buf_q    <= {{(HdrMax-1){8'h00}}, pay_byte};
        is_hdr_q <= 1'b0;
      end else begin
        buf_q    <= hdr;
        is_hdr_q <= 1'b1;
      end
    end else if (take) begin
      for (int i = 0; i < int'(HdrMax) - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[HdrMax-1] <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = buf_q[0];
  assign is_header_o = is_hdr_q;
  assign run_last_o  = last;

endmodule

// ----- rtl/wsfe_checker.sv -----
// Port-level assertions for the WebSocket frame encoder, bound to the top level.
module wsfe_checker
  import wsfe_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        is_header_o,
  input logic        run_last_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_header_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // no new word taken while bytes of the current one remain
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> in_stall_o)
    else $error("input taken mid-frame-run");

  // a payload word gives exactly one non-header byte next
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_e'(mode_i) == MODE_PAYLOAD |=> out_valid_o && !is_header_o && run_last_o)
    else $error("payload word misframed");

  // a start word gives at least two header bytes
  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_e'(mode_i) == MODE_START |=> out_valid_o && is_header_o && !run_last_o)
    else $error("header word misframed");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (.*);

// ----- sim/websocket_frame_encoder_test.sv -----
// Self-checking testbench for the WebSocket frame encoder: header bytes, masking, idling.
`timescale 1ns / 100ps

module websocket_frame_encoder_test;
  import wsfe_pkg::*;

  // Run limit in clock cycles. The slowest correct run is every word giving 14 bytes,
  // each held by long output stalls; several times that is still well under this.
  localparam int unsigned CycleLimit = 600_000;
  // Lengths from here on take the 64-bit form.
  localparam logic [63:0] MidLim = 64'd65536;

  // One input word as the sender presents it.
  typedef struct {
    mode_e       mode;
    logic [3:0]  opcode;
    logic [63:0] len;
    logic [7:0]  data;
  } frame_word_t;

  // One output byte as it should appear on the wire.
  typedef struct {
    logic [7:0] value;
    logic       is_hdr;
    logic       is_last;
  } frame_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              mode_i;
  logic [3:0]        opcode_i;
  logic [63:0]       payload_length_i;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        out_byte_o;
  logic              is_header_o;
  logic              run_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  websocket_frame_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .opcode_i         (opcode_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .is_header_o      (is_header_o),
    .run_last_o       (run_last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Predictor's copy of the configuration and the mask phase; reset values as the block's.
  logic        mask_on   = 1'b0;
  logic [31:0] mask_key  = KeyReset;
  logic [1:0]  key_phase = 2'd0;

  // Bytes still owed by the block, oldest first.
  frame_byte_t expected_bytes[$];

  // Idling percentages for the current phase.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Run statistics.
  int unsigned err_count     = 0;
  int unsigned words_sent    = 0;
  int unsigned header_words  = 0;
  int unsigned masked_bytes  = 0;
  int unsigned bytes_checked = 0;
  int unsigned regs_written  = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still expected",
               cycle_count, expected_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall, redrawn every cycle at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [7:0] mask_key_byte(logic [1:0] idx);
    return mask_key[8 * (3 - int'(idx)) +: 8];
  endfunction

  // Works out the bytes one accepted word must produce and queues them.
  function automatic void predict_frame_bytes(frame_word_t w);
    logic [7:0] hb[$];
    logic [7:0] mbit;
    logic [7:0] b;
    if (w.mode == MODE_PAYLOAD) begin
      b = w.data;
      if (mask_on) begin
        b = b ^ mask_key_byte(key_phase);
        masked_bytes++;
      end
      // phase moves on every payload byte, masked or not
      key_phase = key_phase + 2'd1;
      expected_bytes.insert(expected_bytes.size(), '{b, 1'b0, 1'b1});
    end else begin
      mbit = mask_on ? MaskBit : 8'h00;
      hb.insert(hb.size(), FinBit | {4'h0, w.opcode});
      if (w.len < ShortLim) begin
        hb.insert(hb.size(), {1'b0, w.len[6:0]} | mbit);
      end else if (w.len < MidLim) begin
        hb.insert(hb.size(), {1'b0, Len16Mark} | mbit);
        hb.insert(hb.size(), w.len[15:8]);
        hb.insert(hb.size(), w.len[7:0]);
      end else begin
        hb.insert(hb.size(), {1'b0, Len64Mark} | mbit);
        for (int i = 7; i >= 0; i--) hb.insert(hb.size(), w.len[8 * i +: 8]);
      end
      if (mask_on) begin
        for (int i = 0; i < 4; i++) hb.insert(hb.size(), mask_key_byte(2'(i)));
      end
      key_phase = 2'd0;
      foreach (hb[i])
        expected_bytes.insert(expected_bytes.size(), '{hb[i], 1'b1, i == hb.size() - 1});
      header_words++;
    end
  endfunction

  // Input monitor and output checker. Prediction runs first so a byte can never
  // overtake the word that causes it.
  always @(posedge clk_i) begin : check_output
    frame_word_t seen;
    frame_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen.mode   = mode_e'(mode_i);
        seen.opcode = opcode_i;
        seen.len    = payload_length_i;
        seen.data   = data_byte_i;
        predict_frame_bytes(seen);
        words_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          report_error($sformatf("unexpected byte %02h (hdr %0b last %0b)",
                                 out_byte_o, is_header_o, run_last_o));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.value)
            report_error($sformatf("out_byte %02h, want %02h", out_byte_o, want.value));
          if (is_header_o !== want.is_hdr)
            report_error($sformatf("is_header %0b, want %0b on byte %02h",
                                   is_header_o, want.is_hdr, want.value));
          if (run_last_o !== want.is_last)
            report_error($sformatf("run_last %0b, want %0b on byte %02h",
                                   run_last_o, want.is_last, want.value));
          bytes_checked++;
        end
      end
    end
  end

  // Presents one word and holds it until taken. Valid stays high on return, so
  // back-to-back words stream without a gap unless the idle draw says otherwise.
  task automatic send_word(frame_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i       <= 1'b0;
      // scribble on the idle payload; it must be ignored
      mode_i           <= 1'($urandom);
      data_byte_i      <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= w.mode;
    opcode_i         <= w.opcode;
    payload_length_i <= w.len;
    data_byte_i      <= w.data;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_start(logic [3:0] opcode, logic [63:0] len);
    send_word('{MODE_START, opcode, len, 8'($urandom)});
  endtask

  task automatic send_byte(logic [7:0] data);
    send_word('{MODE_PAYLOAD, 4'($urandom), {$urandom, $urandom}, data});
  endtask

  // Drops valid and waits for every owed byte, then as many quiet cycles as extra asks.
  // Returns at a falling edge.
  task automatic wait_idle(int unsigned extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // APB write then read-back of one register; call at a falling edge with the block idle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_USE_MASK) mask_on = value[0];
    else mask_key = value;
    regs_written++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_USE_MASK) begin
      if (prdata[0] !== mask_on)
        report_error($sformatf("use_mask reads %0b, want %0b", prdata[0], mask_on));
    end else if (prdata !== mask_key) begin
      report_error($sformatf("mask key reads %08h, want %08h", prdata, mask_key));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reconfigure(logic use_mask, logic [31:0] key);
    wait_idle(4);
    write_reg(REG_KEY, key);
    write_reg(REG_USE_MASK, {31'd0, use_mask});
  endtask

  // Lengths spread over all three encodings, with their edges, and whole 64-bit values.
  function automatic logic [63:0] rand_len();
    case ($urandom_range(7))
      0:       return 64'($urandom_range(125));
      1:       return 64'($urandom_range(65535, 126));
      2:       return ($urandom_range(1)) ? 64'd125 : 64'd126;
      3:       return ($urandom_range(1)) ? 64'd65535 : MidLim;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed: reset configuration, unmasked headers of every length form.
  task automatic test_unmasked_headers();
    send_byte(8'hA5);                           // payload before any header
    send_start(4'd1, 64'd0);
    send_start(4'd2, 64'd125);
    send_start(4'd0, 64'd126);
    send_start(4'd8, 64'd65535);
    send_start(4'd9, MidLim);
    send_start(4'd10, '1);
    send_start(4'd15, 64'h8000_0000_0000_0001); // top bit set, passed through
    send_byte(8'h00);
  endtask

  // Directed: masking with the reset key, phase wrap and more bytes than announced.
  task automatic test_masked_frames();
    reconfigure(1'b1, KeyReset);
    send_start(4'd2, 64'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hC3);
    send_byte(8'h3C);                           // fifth byte wraps back to key byte 0
    send_start(4'd1, 64'd300);
  endtask

  // Directed: all-zero and all-ones keys.
  task automatic test_key_extremes();
    reconfigure(1'b1, 32'h0000_0000);
    send_start(4'd2, 64'd2);
    send_byte(8'hFF);
    reconfigure(1'b1, 32'hFFFF_FFFF);
    send_start(4'd2, 64'd70000);
    send_byte(8'h00);
    send_byte(8'h81);
  endtask

  // Directed: masking switched off and on inside one frame; phase keeps counting.
  task automatic test_mask_toggle();
    reconfigure(1'b1, $urandom);
    send_start(4'd1, 64'd4);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    wait_idle(4);
    write_reg(REG_USE_MASK, 32'd0);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    wait_idle(4);
    write_reg(REG_USE_MASK, 32'd1);
    send_byte(8'($urandom));
  endtask

  // Random frames: mostly a header followed by a burst of payload bytes, with some
  // stray payload runs as noise. Now and then the sender holds off until the block
  // has drained, and sometimes flips masking while it is quiet.
  task automatic test_random_traffic(int unsigned idle, int unsigned stall,
                                     int unsigned n_words);
    int unsigned sent;
    int unsigned n_pay;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) != 0) begin
        send_start(4'($urandom), rand_len());
        sent++;
      end
      n_pay = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(8);
      repeat (n_pay) begin
        send_byte(8'($urandom));
        sent++;
      end
      if ($urandom_range(24) == 0) begin
        wait_idle(4);
        if ($urandom_range(1)) write_reg(REG_USE_MASK, {31'd0, ~mask_on});
      end
    end
    wait_idle(4);
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    in_valid_i       = 1'b0;
    mode_i           = MODE_START;
    opcode_i         = '0;
    payload_length_i = '0;
    data_byte_i      = '0;
    out_stall_i      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rst_ni           = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_unmasked_headers();
    test_masked_frames();
    test_key_extremes();
    test_mask_toggle();

    // random phases: none, sender gaps, receiver stalls, light both
    reconfigure(1'b1, $urandom);
    test_random_traffic(0, 0, 110);
    reconfigure(1'b0, 32'h0000_0000);
    test_random_traffic(58, 0, 110);
    reconfigure(1'b1, 32'hFFFF_FFFF);
    test_random_traffic(0, 58, 110);
    reconfigure(1'($urandom), $urandom);
    test_random_traffic(6, 6, 110);

    wait_idle(20);
    $display("Covered %0d words (%0d frame headers), %0d bytes checked, %0d masked.",
             words_sent, header_words, bytes_checked, masked_bytes);
    $display("%0d register writes with read-back, %0d cycles, %0d errors.",
             regs_written, cycle_count, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wsfe_pkg.sv
rtl/websocket_frame_encoder.sv
rtl/wsfe_checker.sv
sim/websocket_frame_encoder_test.sv
